// File: design/ffa_pkg.sv
package ffa_pkg;

	localparam int unsigned DEF_MEM_UNITS   = 1024;
	localparam int unsigned DEF_MAX_EXTENTS = 1024;
	localparam int unsigned DEF_ID_BITS     = 10;

	localparam int unsigned CFG_ADDR_BITS = 3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_MEM_SIZE = 3'd0;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_A_RD   = 10'b00_0000_0010,
		ST_A_EV   = 10'b00_0000_0100,
		ST_SH_RD  = 10'b00_0000_1000,
		ST_SH_WR  = 10'b00_0001_0000,
		ST_INS    = 10'b00_0010_0000,
		ST_F_RD   = 10'b00_0100_0000,
		ST_F_EV   = 10'b00_1000_0000,
		ST_DONE   = 10'b01_0000_0000,
		ST_CHECK  = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic load_req;
		logic rd_cur;
		logic rd_prev;
		logic start_shift;
		logic step_gap;
		logic shift_wr;
		logic insert;
		logic free_step;
		logic free_close;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic idx_at_count;
		logic idx_at_pos;
		logic gap_fits;
		logic tail_fits;
		logic req_bad;
		logic kind_free;
		logic out_free;
	} status_t;

endpackage

// File: design/ffa_ram.sv
module ffa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/ffa_ctrl.sv
module ffa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	output logic             in_ready,
	input  ffa_pkg::status_t st,
	output ffa_pkg::cmd_t    cmd
);
	import ffa_pkg::*;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load_req = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (st.kind_free) begin
					state_d = ST_F_RD;
				end else if (st.req_bad) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_A_RD;
				end
			end
			ST_A_RD: begin
				if (st.idx_at_count) begin
					if (st.tail_fits) begin
						cmd.start_shift = 1'b1;
						state_d = ST_SH_RD;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					cmd.rd_cur = 1'b1;
					state_d = ST_A_EV;
				end
			end
			ST_A_EV: begin
				if (st.gap_fits) begin
					cmd.start_shift = 1'b1;
					state_d = ST_SH_RD;
				end else begin
					cmd.step_gap = 1'b1;
					state_d = ST_A_RD;
				end
			end
			ST_SH_RD: begin
				if (st.idx_at_pos) begin
					state_d = ST_INS;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d = ST_SH_WR;
				end
			end
			ST_SH_WR: begin
				cmd.shift_wr = 1'b1;
				state_d = ST_SH_RD;
			end
			ST_INS: begin
				cmd.insert = 1'b1;
				state_d = ST_DONE;
			end
			ST_F_RD: begin
				if (st.idx_at_count) begin
					cmd.free_close = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d = ST_F_EV;
				end
			end
			ST_F_EV: begin
				cmd.free_step = 1'b1;
				state_d = ST_F_RD;
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/ffa_dp.sv
module ffa_dp #(
	parameter int unsigned MEM_UNITS   = ffa_pkg::DEF_MEM_UNITS,
	parameter int unsigned MAX_EXTENTS = ffa_pkg::DEF_MAX_EXTENTS,
	parameter int unsigned ID_BITS     = ffa_pkg::DEF_ID_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffa_pkg::cmd_t                  cmd,
	output ffa_pkg::status_t               st,
	input  logic [$clog2(MEM_UNITS):0]     mem_size,
	input  logic                           in_kind,
	input  logic [$clog2(MEM_UNITS):0]     in_size,
	input  logic [ID_BITS-1:0]             in_owner,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           out_ok,
	output logic [$clog2(MEM_UNITS)-1:0]   out_addr,
	output logic [$clog2(MEM_UNITS):0]     out_freed
);
	import ffa_pkg::*;

	localparam int unsigned AW = $clog2(MEM_UNITS);
	localparam int unsigned IW = $clog2(MAX_EXTENTS);
	localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
	localparam int unsigned EW = 2 * AW + ID_BITS;
	localparam logic [AW:0] UNITS_C = (AW + 1)'(MEM_UNITS);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_EXTENTS);

	logic [CW-1:0]    idx_q, pos_q, count_q, keep_q;
	logic [AW:0]      nf_q, total_q, size_q;
	logic [ID_BITS-1:0] owner_q;
	logic             kind_q, ok_q;

	logic             we;
	logic [IW-1:0]    waddr, raddr;
	logic [EW-1:0]    wdata, rdata;
	logic [AW-1:0]    r_start, r_end;
	logic [ID_BITS-1:0] r_owner;
	logic [AW:0]      limit, gap, span;

	assign r_start = rdata[AW-1:0];
	assign r_end   = rdata[2*AW-1:AW];
	assign r_owner = rdata[EW-1:2*AW];

	assign limit = (mem_size > UNITS_C) ? UNITS_C : mem_size;
	assign gap   = {1'b0, r_start} - nf_q;
	assign span  = {1'b0, r_end} - {1'b0, r_start} + (AW + 1)'(1);

	assign st.idx_at_count = (idx_q == count_q);
	assign st.idx_at_pos   = (idx_q == pos_q);
	assign st.gap_fits     = ({1'b0, r_start} >= nf_q) && (gap >= size_q);
	assign st.tail_fits    = (nf_q <= limit) && ((limit - nf_q) >= size_q);
	assign st.req_bad      = (size_q == '0) || (count_q == MAX_C);
	assign st.kind_free    = (kind_q == KIND_FREE);
	assign st.out_free     = !out_valid || out_ready;

	// Memory port steering
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = rdata;
		raddr = idx_q[IW-1:0];
		if (cmd.rd_prev) begin
			raddr = IW'(idx_q - CW'(1));
		end else if (cmd.rd_cur) begin
			raddr = idx_q[IW-1:0];
		end
		if (cmd.shift_wr) begin
			we = 1'b1;
		end else if (cmd.insert) begin
			we    = 1'b1;
			waddr = pos_q[IW-1:0];
			wdata = {owner_q, AW'(nf_q + size_q - (AW + 1)'(1)), nf_q[AW-1:0]};
		end else if (cmd.free_step && (r_owner != owner_q)) begin
			we    = 1'b1;
			waddr = keep_q[IW-1:0];
		end
	end

	ffa_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			size_q  <= in_size;
			owner_q <= in_owner;
			kind_q  <= in_kind;
			nf_q    <= '0;
			total_q <= '0;
			keep_q  <= '0;
			ok_q    <= 1'b0;
		end
		if (cmd.start_shift) begin
			pos_q <= idx_q;
		end
		if (cmd.step_gap) begin
			nf_q <= {1'b0, r_end} + (AW + 1)'(1);
		end
		if (cmd.insert) begin
			ok_q <= 1'b1;
		end
		if (cmd.free_step) begin
			if (r_owner == owner_q) begin
				total_q <= total_q + span;
			end else begin
				keep_q <= keep_q + CW'(1);
			end
		end
		if (cmd.publish) begin
			out_ok    <= ok_q;
			out_addr  <= ok_q ? nf_q[AW-1:0] : '0;
			out_freed <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				idx_q <= '0;
			end else if (cmd.start_shift) begin
				idx_q <= count_q;
			end else if (cmd.step_gap || cmd.free_step) begin
				idx_q <= idx_q + CW'(1);
			end else if (cmd.shift_wr) begin
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.free_close) begin
				count_q <= keep_q;
			end
			if (cmd.publish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// File: design/first_fit_extent_allocator.sv
// First-fit extent allocator.
// Slave stream s_*: one request per transfer. s_tuser = kind (0 allocate,
// 1 free); s_tdata = alloc_size, then owner_id, zero padded to bytes.
// Master stream m_*: one result per request. m_tuser = alloc_ok; m_tdata =
// alloc_addr, then freed_units, zero padded to bytes.
// APB port: register mem_size at byte address 0, written in the access phase.
// An allocate reads the extents in order during the search, then moves
// each extent after the chosen slot up by one place to open it, then
// writes the new extent; a request rejected up front (zero size, full list)
// goes straight to the result. A free reads each live extent once and
// compacts those it keeps. Both loops are set by the single read port of the
// extent memory; extents read and moved together are at most one more than
// the extent count. One request is worked at a time:
// s_tready is high only while the engine is idle.
// Reset clears the extent count and sets mem_size to MEM_UNITS; the extent
// memory is not cleared, since entries at or beyond the count are never read.
// A stalled receiver holds the result in the output register; the engine
// takes the next request meanwhile and waits at its end for the register.
module first_fit_extent_allocator #(
	parameter int unsigned MEM_UNITS   = ffa_pkg::DEF_MEM_UNITS,
	parameter int unsigned MAX_EXTENTS = ffa_pkg::DEF_MAX_EXTENTS,
	parameter int unsigned ID_BITS     = ffa_pkg::DEF_ID_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: alloc_size, owner_id (from bit 0 up), zero padded
	input  logic [((($clog2(MEM_UNITS) + 1 + ID_BITS) + 7) / 8) * 8 - 1:0] s_tdata,
	// tuser: kind
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: alloc_addr, freed_units (from bit 0 up), zero padded
	output logic [((2 * $clog2(MEM_UNITS) + 1 + 7) / 8) * 8 - 1:0] m_tdata,
	// tuser: alloc_ok
	output logic m_tuser,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ffa_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ffa_pkg::*;

	localparam int unsigned AW  = $clog2(MEM_UNITS);
	localparam int unsigned OTW = ((2 * AW + 1 + 7) / 8) * 8;

	logic [AW:0]   mem_size_q;
	logic          in_fire;
	cmd_t          cmd;
	status_t       st;
	logic          res_ok;
	logic [AW-1:0] res_addr;
	logic [AW:0]   res_freed;

	// Configuration: single register, always ready
	assign pready = 1'b1;
	assign prdata = (paddr == REG_MEM_SIZE) ? 32'(mem_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= (AW + 1)'(MEM_UNITS);
		end else if (psel && penable && pwrite && (paddr == REG_MEM_SIZE)) begin
			mem_size_q <= pwdata[AW:0];
		end
	end

	assign in_fire = s_tvalid && s_tready;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ffa_dp #(
		.MEM_UNITS   (MEM_UNITS),
		.MAX_EXTENTS (MAX_EXTENTS),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.mem_size  (mem_size_q),
		.in_kind   (s_tuser),
		.in_size   (s_tdata[AW:0]),
		.in_owner  (s_tdata[AW + ID_BITS:AW + 1]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_ok    (res_ok),
		.out_addr  (res_addr),
		.out_freed (res_freed)
	);

	// Pack the held result onto the master stream
	assign m_tuser = res_ok;
	assign m_tdata = OTW'({res_freed, res_addr});

endmodule

// File: test/ffa_checker.sv
module ffa_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	import ffa_pkg::*;

	localparam int UNITS = 1024;
	localparam int SLOTS = 1024;

	typedef struct packed {
		logic       ok;
		logic [9:0] addr;
		logic [10:0] freed;
	} outcome_t;

	logic [10:0] size_reg;
	int unsigned ext_lo [SLOTS];
	int unsigned ext_hi [SLOTS];
	logic [9:0]  ext_tag [SLOTS];
	int unsigned ext_n;
	outcome_t    awaited [$];

	function automatic outcome_t place_extent(int unsigned want, logic [9:0] tag);
		outcome_t o;
		int unsigned lim, gap_at, pos;
		o = '0;
		lim = (size_reg > UNITS) ? UNITS : size_reg;
		gap_at = 0;
		pos = 0;
		if (want == 0 || ext_n >= SLOTS)
			return o;
		while (pos < ext_n) begin
			if (ext_lo[pos] >= gap_at && ext_lo[pos] - gap_at >= want)
				break;
			gap_at = ext_hi[pos] + 1;
			pos++;
		end
		if (pos >= ext_n && (gap_at > lim || lim - gap_at < want))
			return o;
		for (int unsigned k = ext_n; k > pos; k--) begin
			ext_lo[k] = ext_lo[k-1];
			ext_hi[k] = ext_hi[k-1];
			ext_tag[k] = ext_tag[k-1];
		end
		ext_lo[pos] = gap_at;
		ext_hi[pos] = gap_at + want - 1;
		ext_tag[pos] = tag;
		ext_n++;
		o.ok = 1'b1;
		o.addr = gap_at[9:0];
		return o;
	endfunction

	function automatic outcome_t release_owner(logic [9:0] tag);
		outcome_t o;
		int unsigned total, keep;
		o = '0;
		total = 0;
		keep = 0;
		for (int unsigned k = 0; k < ext_n; k++) begin
			if (ext_tag[k] == tag) begin
				total += ext_hi[k] - ext_lo[k] + 1;
			end else begin
				ext_lo[keep] = ext_lo[k];
				ext_hi[keep] = ext_hi[k];
				ext_tag[keep] = ext_tag[k];
				keep++;
			end
		end
		ext_n = keep;
		o.freed = total[10:0];
		return o;
	endfunction

	assign pending = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_o, got;
		if (!arst_n) begin
			size_reg = 11'd1024;
			ext_n = 0;
			awaited.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_MEM_SIZE)
				size_reg = pwdata[10:0];
			if (m_tvalid && m_tready) begin
				got.ok = m_tuser;
				got.addr = m_tdata[9:0];
				got.freed = m_tdata[20:10];
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result ok=%0d addr=%0d freed=%0d",
						$time, got.ok, got.addr, got.freed);
					fail_count++;
				end else begin
					exp_o = awaited.pop_front();
					if (got.ok !== exp_o.ok || got.addr !== exp_o.addr
						|| got.freed !== exp_o.freed) begin
						$display("%0t: expected ok=%0d addr=%0d freed=%0d, got ok=%0d addr=%0d freed=%0d",
							$time, exp_o.ok, exp_o.addr, exp_o.freed,
							got.ok, got.addr, got.freed);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == KIND_FREE)
					awaited.insert(awaited.size(), release_owner(s_tdata[20:11]));
				else
					awaited.insert(awaited.size(),
						place_extent(s_tdata[10:0], s_tdata[20:11]));
			end
		end
	end
endmodule

// File: test/tb_first_fit_extent_allocator.sv
module tb_first_fit_extent_allocator;
	import ffa_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// tdata: alloc_size[10:0], owner_id[20:11], zero padded
	logic [23:0] s_tdata = '0;
	// tuser: kind
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// tdata: alloc_addr[9:0], freed_units[20:10], zero padded
	logic [23:0] m_tdata;
	// tuser: alloc_ok
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	bit          hold_sink = 1'b0;

	always #5 clk = ~clk;

	first_fit_extent_allocator dut (.*);

	ffa_checker chk (.*);

	// Pick a gap length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Offer one request; hold it until the transfer happens. Valid stays
	// high afterwards so a request without a gap follows back to back.
	task automatic send_req(logic kind, logic [10:0] size, logic [9:0] owner, bit idle_gaps);
		int g;
		g = idle_gaps ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {3'b000, owner, size};
		do @(posedge clk); while (!s_tready);
	endtask

	// Write mem_size through the APB port: setup cycle, then access cycle.
	task automatic write_mem_size(logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MEM_SIZE;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drop valid, drain every outstanding result, then let the engine settle.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_sink = 1'b0;
			end
			g = gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int r;
		logic [9:0] owner;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero size, no-match free, free of a full memory.
		send_req(KIND_ALLOC, 11'd0, 10'd1, 0);
		send_req(KIND_ALLOC, 11'd1024, 10'd1023, 0);
		send_req(KIND_ALLOC, 11'd1, 10'd2, 0);
		send_req(KIND_FREE, 11'd2047, 10'd1023, 0);
		send_req(KIND_FREE, 11'd0, 10'd500, 0);
		send_req(KIND_ALLOC, 11'd2047, 10'd3, 0);
		send_req(KIND_ALLOC, 11'd5, 10'd0, 0);
		send_req(KIND_ALLOC, 11'd3, 10'd341, 0);
		send_req(KIND_ALLOC, 11'd7, 10'd682, 0);
		send_req(KIND_FREE, 11'd1365, 10'd341, 0);
		send_req(KIND_ALLOC, 11'd2, 10'd4, 0);
		send_req(KIND_ALLOC, 11'd1, 10'd4, 0);
		send_req(KIND_FREE, 11'd0, 10'd4, 0);
		settle();

		// Shrink below live extents: tail gap vanishes, inner gaps stay.
		write_mem_size(32'd8);
		send_req(KIND_ALLOC, 11'd3, 10'd9, 0);
		send_req(KIND_ALLOC, 11'd1, 10'd9, 0);
		settle();
		write_mem_size(32'd0);
		send_req(KIND_ALLOC, 11'd1, 10'd9, 0);
		settle();
		write_mem_size(32'h7FF);
		send_req(KIND_ALLOC, 11'd1000, 10'd9, 0);
		send_req(KIND_FREE, 11'd0, 10'd9, 0);
		send_req(KIND_FREE, 11'd0, 10'd0, 0);
		send_req(KIND_FREE, 11'd0, 10'd682, 0);
		settle();

		// Random phases across several memory sizes; stall the sink once.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_mem_size(32'd1024);
				1: write_mem_size(32'd1);
				2: write_mem_size($urandom_range(20, 200));
				default: write_mem_size(32'd1024);
			endcase
			if (ph == 3)
				hold_sink = 1'b1;
			for (int i = 0; i < 68; i++) begin
				r = $urandom_range(0, 99);
				owner = (r < 90) ? 10'($urandom_range(0, 7)) : 10'($urandom);
				if (r < 60)
					send_req(KIND_ALLOC,
						($urandom_range(0, 9) == 0) ? 11'($urandom)
						: 11'($urandom_range(1, 64)), owner, ph != 3);
				else
					send_req(KIND_FREE, 11'($urandom), owner, ph != 3);
			end
			settle();
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
